>>> design/bir_pkg.sv
`default_nettype none

package bir_pkg;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 256;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 256;
  localparam int unsigned DEF_MAX_CHANNELS   = 4;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned PIX_W   = 32;

  // Destination sizes are clamped to this range.
  localparam logic [SIZE_W-1:0] DST_MIN = 13'd2;
  localparam logic [SIZE_W-1:0] DST_MAX = 13'd4096;

  // Request kinds as they come in on tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Operations handed from the front to the back.
  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_FETCH     = 2'd1;
  localparam logic [1:0] OP_RANGE_ERR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHANNELS   = 3'd4;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [SIZE_W-1:0] dst_w;
    logic [SIZE_W-1:0] dst_h;
    logic [2:0]        nch;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pix;
  } req_t;

endpackage

`default_nettype wire

>>> design/bir_front.sv
`default_nettype none

module bir_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  bir_pkg::cfg_t               cfg,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_kind,
  input  wire  [bir_pkg::COORD_W-1:0] in_row,
  input  wire  [bir_pkg::COORD_W-1:0] in_col,
  input  wire  [bir_pkg::PIX_W-1:0]   in_pix,
  output logic                        req_valid,
  input  wire                         req_pop,
  output bir_pkg::req_t               req
);

  bir_pkg::req_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          keep;
  logic          push;
  bir_pkg::req_t entry;

  always_comb begin
    entry.row = in_row;
    entry.col = in_col;
    entry.pix = in_pix;
    keep      = 1'b1;
    if (in_kind == bir_pkg::REQ_LOAD) begin
      entry.op = bir_pkg::OP_LOAD;
      // Loads outside the source image are dropped here.
      if ({1'b0, in_row} >= cfg.src_h || {1'b0, in_col} >= cfg.src_w) begin
        keep = 1'b0;
      end
    end else if ({1'b0, in_row} >= cfg.dst_h || {1'b0, in_col} >= cfg.dst_w) begin
      entry.op = bir_pkg::OP_RANGE_ERR;
    end else begin
      entry.op = bir_pkg::OP_FETCH;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (req_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !req_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && req_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/bir_back.sv
`default_nettype none

module bir_back #(
  parameter int unsigned MaxSrcW = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MaxSrcH = bir_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  bir_pkg::cfg_t             cfg,
  input  wire                       req_valid,
  output logic                      req_pop,
  input  bir_pkg::req_t             req,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [bir_pkg::PIX_W-1:0] out_pix,
  output logic                      out_err
);

  localparam int unsigned CW    = $clog2(MaxSrcW);
  localparam int unsigned RW    = $clog2(MaxSrcH);
  localparam int unsigned DEPTH = MaxSrcW * MaxSrcH;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_WGT, S_RD, S_QDIV, S_OUT
  } state_t;

  state_t      state_r;
  logic [3:0]  step_r;
  logic [11:0] row_r, col_r;
  logic [11:0] rem_x_r, lo_x_r, rem_y_r, lo_y_r;
  logic [CW-1:0] x_r, x2_r;
  logic [RW-1:0] y_r, y2_r;
  logic [23:0] w_r [4];
  logic [23:0] den_r;
  logic [31:0] acc_r [4];
  logic        out_valid_r;
  logic [31:0] out_pix_r;
  logic        out_err_r;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;
  logic [AW-1:0] ld_addr, rd_addr;
  logic        mem_we;
  logic        out_free;

  logic [11:0] sw, sh, dw, dh;
  logic [23:0] prod_x, prod_y;
  logic [12:0] rs_x, rs_y;
  logic        ge_x, ge_y;
  logic [12:0] df_x, df_y;
  logic [11:0] b_c, n_c, x2_c, y2_c;
  logic [23:0] den_c;
  logic [23:0] wsel;
  logic [31:0] acc_rd [4];
  logic [31:0] acc_qd [4];
  logic [24:0] rs_q [4];
  logic [24:0] df_q [4];
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;

  assign sw = cfg.src_w[11:0] - 12'd1;
  assign sh = cfg.src_h[11:0] - 12'd1;
  assign dw = 12'(cfg.dst_w - 13'd1);
  assign dh = 12'(cfg.dst_h - 13'd1);

  assign out_free = !out_valid_r || out_ready;
  assign req_pop  = (state_r == S_IDLE) && req_valid &&
                    ((req.op != bir_pkg::OP_RANGE_ERR) || out_free);
  assign mem_we   = req_pop && (req.op == bir_pkg::OP_LOAD);
  assign ld_addr  = AW'(req.row[RW-1:0]) * AW'(MaxSrcW) + AW'(req.col[CW-1:0]);

  always_comb begin
    // Neighbors are read in the order upper-left, upper-right, lower-left, lower-right.
    rd_row = step_r[1] ? y2_r : y_r;
    rd_col = step_r[0] ? x2_r : x_r;
  end
  assign rd_addr = AW'(rd_row) * AW'(MaxSrcW) + AW'(rd_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ld_addr] <= req.pix;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    prod_x = 24'(col_r) * 24'(sw);
    prod_y = 24'(row_r) * 24'(sh);
    rs_x   = {rem_x_r, lo_x_r[11]};
    rs_y   = {rem_y_r, lo_y_r[11]};
    df_x   = rs_x - {1'b0, dw};
    df_y   = rs_y - {1'b0, dh};
    ge_x   = rs_x >= {1'b0, dw};
    ge_y   = rs_y >= {1'b0, dh};
    b_c    = dw - rem_x_r;
    n_c    = dh - rem_y_r;
    x2_c   = (rem_x_r == 12'd0) ? lo_x_r : lo_x_r + 12'd1;
    y2_c   = (rem_y_r == 12'd0) ? lo_y_r : lo_y_r + 12'd1;
    den_c  = 24'(dw) * 24'(dh);
    wsel   = w_r[2'(step_r - 4'd1)];
    for (int k = 0; k < 4; k++) begin
      acc_rd[k] = acc_r[k] + 32'(wsel) * 32'(rd_data_r[8*k +: 8]);
      rs_q[k]   = {acc_r[k][31:8], acc_r[k][7]};
      df_q[k]   = rs_q[k] - {1'b0, den_r};
      if (rs_q[k] >= {1'b0, den_r}) begin
        acc_qd[k] = {df_q[k][23:0], acc_r[k][6:0], 1'b1};
      end else begin
        acc_qd[k] = {rs_q[k][23:0], acc_r[k][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (req_pop) begin
            row_r <= req.row;
            col_r <= req.col;
            if (req.op == bir_pkg::OP_FETCH) begin
              state_r <= S_MUL;
            end else if (req.op == bir_pkg::OP_RANGE_ERR) begin
              out_valid_r <= 1'b1;
              out_pix_r   <= '0;
              out_err_r   <= 1'b1;
            end
          end
        end
        S_MUL: begin
          // The quotient fits in 12 bits, so the upper half is already below the divisor.
          rem_x_r <= prod_x[23:12];
          lo_x_r  <= prod_x[11:0];
          rem_y_r <= prod_y[23:12];
          lo_y_r  <= prod_y[11:0];
          step_r  <= 4'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_x_r <= ge_x ? df_x[11:0] : rs_x[11:0];
          lo_x_r  <= {lo_x_r[10:0], ge_x};
          rem_y_r <= ge_y ? df_y[11:0] : rs_y[11:0];
          lo_y_r  <= {lo_y_r[10:0], ge_y};
          step_r  <= step_r + 4'd1;
          if (step_r == 4'd11) begin
            state_r <= S_WGT;
          end
        end
        S_WGT: begin
          x_r    <= lo_x_r[CW-1:0];
          x2_r   <= x2_c[CW-1:0];
          y_r    <= lo_y_r[RW-1:0];
          y2_r   <= y2_c[RW-1:0];
          w_r[0] <= 24'(b_c) * 24'(n_c);
          w_r[1] <= 24'(dw - b_c) * 24'(n_c);
          w_r[2] <= 24'(b_c) * 24'(dh - n_c);
          w_r[3] <= 24'(dw - b_c) * 24'(dh - n_c);
          den_r  <= den_c;
          for (int k = 0; k < 4; k++) begin
            acc_r[k] <= 32'(den_c >> 1);
          end
          step_r  <= 4'd0;
          state_r <= S_RD;
        end
        S_RD: begin
          // Read data arrives in the cycle after its address is presented.
          if (step_r != 4'd0) begin
            for (int k = 0; k < 4; k++) begin
              acc_r[k] <= acc_rd[k];
            end
          end
          if (step_r == 4'd4) begin
            step_r  <= 4'd0;
            state_r <= S_QDIV;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_QDIV: begin
          for (int k = 0; k < 4; k++) begin
            acc_r[k] <= acc_qd[k];
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd7) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_err_r   <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              out_pix_r[8*k +: 8] <= (3'(k) < cfg.nch) ? acc_r[k][7:0] : 8'd0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_err   = out_err_r;

endmodule

`default_nettype wire

>>> design/bilinear_image_resize_top.sv
`default_nettype none

// Bilinear image resizer. A load (tuser 0) writes one source pixel into the frame store;
// a fetch (tuser 1) returns one pixel of the source scaled to the destination size, or
// zeros with tuser set when the coordinates lie outside the destination. The front
// classifies requests into a two-entry queue and can take a new transfer while the back
// works or a result waits. A fetch passes through the 12-step coordinate division, the
// four reads through the single frame store port and the 8-step per-channel normalizing
// division. Source pixels must be loaded before a fetch reads them.
module bilinear_image_resize_top #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_CHANNELS   = bir_pkg::DEF_MAX_CHANNELS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // pixel_row[11:0], pixel_col[23:12], in_chan_0..in_chan_3[55:24]
  input  wire  [55:0] in_tdata,
  // req_type
  input  wire         in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_chan_0..out_chan_3[31:0]
  output logic [31:0] out_tdata,
  // range_error
  output logic        out_tuser,
  input  wire         cfg_wr_en,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_wdata
);

  logic [8:0]  src_w_r, src_h_r;
  logic [12:0] dst_w_r, dst_h_r;
  logic [2:0]  nch_r;
  bir_pkg::cfg_t cfg;
  logic          req_valid, req_pop;
  bir_pkg::req_t req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256;
      src_h_r <= 9'd256;
      dst_w_r <= 13'd256;
      dst_h_r <= 13'd256;
      nch_r   <= 3'd3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bir_pkg::REG_SRC_WIDTH:  src_w_r <= cfg_wdata[8:0];
        bir_pkg::REG_SRC_HEIGHT: src_h_r <= cfg_wdata[8:0];
        bir_pkg::REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        bir_pkg::REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        bir_pkg::REG_CHANNELS:   nch_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_w_r == 9'd0) cfg.src_w = 13'd1;
    else if (13'(src_w_r) > 13'(MAX_SRC_WIDTH)) cfg.src_w = 13'(MAX_SRC_WIDTH);
    else cfg.src_w = 13'(src_w_r);
    if (src_h_r == 9'd0) cfg.src_h = 13'd1;
    else if (13'(src_h_r) > 13'(MAX_SRC_HEIGHT)) cfg.src_h = 13'(MAX_SRC_HEIGHT);
    else cfg.src_h = 13'(src_h_r);
    if (dst_w_r < bir_pkg::DST_MIN) cfg.dst_w = bir_pkg::DST_MIN;
    else if (dst_w_r > bir_pkg::DST_MAX) cfg.dst_w = bir_pkg::DST_MAX;
    else cfg.dst_w = dst_w_r;
    if (dst_h_r < bir_pkg::DST_MIN) cfg.dst_h = bir_pkg::DST_MIN;
    else if (dst_h_r > bir_pkg::DST_MAX) cfg.dst_h = bir_pkg::DST_MAX;
    else cfg.dst_h = dst_h_r;
    if (nch_r == 3'd0) cfg.nch = 3'd1;
    else if (nch_r > 3'(MAX_CHANNELS)) cfg.nch = 3'(MAX_CHANNELS);
    else cfg.nch = nch_r;
  end

  bir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_row    (in_tdata[11:0]),
    .in_col    (in_tdata[23:12]),
    .in_pix    (in_tdata[55:24]),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .req       (req)
  );

  bir_back #(
    .MaxSrcW (MAX_SRC_WIDTH),
    .MaxSrcH (MAX_SRC_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .req       (req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_tdata),
    .out_err   (out_tuser)
  );

endmodule

`default_nettype wire

>>> design/bir_checker.sv
`default_nettype none

module bir_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser
);

  // A result waiting for its transfer is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  // A range error always carries zero channels.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("range error with nonzero channels");

  // Reset leaves no result pending.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bilinear_image_resize_top bir_checker u_bir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> tb/resize_pixel_checker.sv
module resize_pixel_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [55:0] in_tdata,
  input  wire         in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [31:0] out_tdata,
  input  wire         out_tuser,
  input  wire         cfg_wr_en,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_wdata,
  output int          fail_count,
  output int          pixels_checked,
  output int          pixels_pending
);

  typedef struct packed {
    logic [7:0] chan3;
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
    logic       range_error;
  } scaled_pixel_t;

  logic [31:0]   source_pixels [0:65535];
  logic [8:0]    src_w_reg = 9'd256;
  logic [8:0]    src_h_reg = 9'd256;
  logic [12:0]   dst_w_reg = 13'd256;
  logic [12:0]   dst_h_reg = 13'd256;
  logic [2:0]    chan_reg  = 3'd3;
  scaled_pixel_t expected_pixels [$];

  initial begin
    fail_count = 0;
    pixels_checked = 0;
  end

  assign pixels_pending = expected_pixels.size();

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic scaled_pixel_t interpolate_pixel(int unsigned row, int unsigned col);
    scaled_pixel_t res;
    int unsigned sw, sh, dw, dh, nch, x, y, bx, ny, x2, y2;
    logic [31:0] pa, pr, pl, pd;
    longint unsigned wa, wr, wl, wd, den, sum;
    logic [7:0] ch [4];
    sw = clamp_to(src_w_reg, 1, 256) - 1;
    sh = clamp_to(src_h_reg, 1, 256) - 1;
    dw = clamp_to(dst_w_reg, 2, 4096) - 1;
    dh = clamp_to(dst_h_reg, 2, 4096) - 1;
    nch = clamp_to(chan_reg, 1, 4);
    res = '0;
    if (row > dh || col > dw) begin
      res.range_error = 1'b1;
      return res;
    end
    x = col * sw / dw;
    bx = dw - (col * sw) % dw;
    y = row * sh / dh;
    ny = dh - (row * sh) % dh;
    x2 = (bx == dw) ? x : x + 1;
    y2 = (ny == dh) ? y : y + 1;
    pa = source_pixels[y * 256 + x];
    pr = source_pixels[y * 256 + x2];
    pl = source_pixels[y2 * 256 + x];
    pd = source_pixels[y2 * 256 + x2];
    wa = longint'(bx) * ny;
    wr = longint'(dw - bx) * ny;
    wl = longint'(bx) * (dh - ny);
    wd = longint'(dw - bx) * (dh - ny);
    den = longint'(dw) * dh;
    for (int k = 0; k < 4; k++) begin
      sum = wa * pa[8*k +: 8] + wr * pr[8*k +: 8] + wl * pl[8*k +: 8]
          + wd * pd[8*k +: 8] + den / 2;
      ch[k] = (k < nch) ? 8'(sum / den) : 8'd0;
    end
    res.chan0 = ch[0];
    res.chan1 = ch[1];
    res.chan2 = ch[2];
    res.chan3 = ch[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on result %0d: %s is 0x%0h, expected 0x%0h",
             pixels_checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    scaled_pixel_t want;
    logic [11:0] row, col;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bir_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_wdata[8:0];
          bir_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_wdata[8:0];
          bir_pkg::REG_DST_WIDTH:  dst_w_reg <= cfg_wdata;
          bir_pkg::REG_DST_HEIGHT: dst_h_reg <= cfg_wdata;
          bir_pkg::REG_CHANNELS:   chan_reg  <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      // Results are retired before this edge's request is predicted.
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result transfer", out_tdata, 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata[7:0] !== want.chan0) report_mismatch("chan0", out_tdata[7:0], want.chan0);
          if (out_tdata[15:8] !== want.chan1)
            report_mismatch("chan1", out_tdata[15:8], want.chan1);
          if (out_tdata[23:16] !== want.chan2)
            report_mismatch("chan2", out_tdata[23:16], want.chan2);
          if (out_tdata[31:24] !== want.chan3)
            report_mismatch("chan3", out_tdata[31:24], want.chan3);
          if (out_tuser !== want.range_error)
            report_mismatch("range_error", out_tuser, want.range_error);
          pixels_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        row = in_tdata[11:0];
        col = in_tdata[23:12];
        if (in_tuser == bir_pkg::REQ_FETCH) begin
          expected_pixels.push_back(interpolate_pixel(row, col));
        end else if (row < clamp_to(src_h_reg, 1, 256) && col < clamp_to(src_w_reg, 1, 256)) begin
          source_pixels[row * 256 + col] = in_tdata[55:24];
        end
      end
    end
  end

endmodule

>>> tb/tb_bilinear_image_resize_top.sv
module tb_bilinear_image_resize_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ITEM_TARGET    = 1750;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  int fail_count, pixels_checked, pixels_pending;
  int loads_sent = 0, fetches_sent = 0, setups = 0;
  int eff_sw, eff_sh, eff_dw, eff_dh;
  int idle_cycles = 0;
  int ready_pct = 100, ready_mode_cnt = 0, hold_cnt = 0;
  logic hold_kick = 1'b0, hold_ack = 1'b0;
  logic burst_mode = 1'b0;

  always #5 clk = ~clk;

  bilinear_image_resize_top u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  resize_pixel_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .fail_count, .pixels_checked, .pixels_pending
  );

  // Receiver: ready level drifts between modes, with rare stalls and one
  // long hold-off on request to back up the input.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_kick != hold_ack) begin
      hold_ack <= hold_kick;
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_cnt <= $urandom_range(20, 60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
    if (ready_mode_cnt == 0) begin
      ready_mode_cnt <= 200;
      case ($urandom_range(0, 2))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        default: ready_pct <= 30;
      endcase
    end else begin
      ready_mode_cnt <= ready_mode_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic send_item(logic kind, int row, int col, logic [31:0] pix);
    int gap, sel;
    sel = $urandom_range(0, 99);
    gap = burst_mode ? 0 : (sel < 60) ? 0 : (sel < 90) ? $urandom_range(1, 3) :
          (sel < 98) ? $urandom_range(4, 10) : $urandom_range(20, 60);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {pix, 12'(col), 12'(row)};
    do @(posedge clk); while (!in_tready);
    if (kind == bir_pkg::REQ_FETCH) fetches_sent++;
    else if (row < eff_sh && col < eff_sw) loads_sent++;
  endtask

  // Reprogram only when idle: all results in, then time for queued loads to finish.
  task automatic set_geometry(int sw, int sh, int dw, int dh, int nch);
    int vals [5];
    logic [2:0] idx [5];
    vals = '{sw, sh, dw, dh, nch};
    idx = '{bir_pkg::REG_SRC_WIDTH, bir_pkg::REG_SRC_HEIGHT, bir_pkg::REG_DST_WIDTH,
            bir_pkg::REG_DST_HEIGHT, bir_pkg::REG_CHANNELS};
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= 13'(vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    eff_sw = clamp_to(sw & 'h1FF, 1, 256);
    eff_sh = clamp_to(sh & 'h1FF, 1, 256);
    eff_dw = clamp_to(dw & 'h1FFF, 2, 4096);
    eff_dh = clamp_to(dh & 'h1FFF, 2, 4096);
    setups++;
  endtask

  task automatic load_source_frame();
    for (int r = 0; r < eff_sh; r++)
      for (int c = 0; c < eff_sw; c++)
        send_item(bir_pkg::REQ_LOAD, r, c, $urandom());
  endtask

  task automatic mixed_traffic(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)
        send_item(bir_pkg::REQ_FETCH, $urandom_range(0, eff_dh - 1),
                  $urandom_range(0, eff_dw - 1), '0);
      else if (sel < 80)
        send_item(bir_pkg::REQ_LOAD, $urandom_range(0, eff_sh - 1),
                  $urandom_range(0, eff_sw - 1), $urandom());
      else if (sel < 90)
        send_item(bir_pkg::REQ_FETCH, $urandom_range(eff_dh, 4095), $urandom_range(0, 4095),
                  $urandom());
      else
        send_item(bir_pkg::REQ_LOAD, $urandom_range(eff_sh, 4095), $urandom_range(0, 4095),
                  $urandom());
    end
  endtask

  initial begin
    int sw, sh, dw, dh, sel;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a small frame with extreme bytes, corners, channel settings 0, 2, 4 and 6.
    set_geometry(4, 3, 7, 5, 4);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        send_item(bir_pkg::REQ_LOAD, r, c,
                  ((r + c) % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
    send_item(bir_pkg::REQ_LOAD, 1, 2, 32'h80FF_017F);
    send_item(bir_pkg::REQ_FETCH, 0, 0, '0);
    send_item(bir_pkg::REQ_FETCH, 4, 6, '0);
    send_item(bir_pkg::REQ_FETCH, 2, 3, '0);
    send_item(bir_pkg::REQ_FETCH, 1, 5, '0);
    send_item(bir_pkg::REQ_FETCH, 5, 0, '0);
    send_item(bir_pkg::REQ_FETCH, 4095, 4095, 32'hFFFF_FFFF);
    send_item(bir_pkg::REQ_LOAD, 4095, 4095, 32'h1234_5678);
    send_item(bir_pkg::REQ_FETCH, 3, 3, '0);
    for (int n = 0; n <= 7; n += 2) begin
      set_geometry(4, 3, 1, 0, n);
      send_item(bir_pkg::REQ_FETCH, 1, 1, '0);
    end

    // Extremes: widest and tallest source, largest and clamped destinations.
    burst_mode = 1'b1;
    set_geometry(300, 0, 8191, 3, 7);
    load_source_frame();
    burst_mode = 1'b0;
    mixed_traffic(30);
    send_item(bir_pkg::REQ_FETCH, 2, 4095, '0);
    set_geometry(1, 256, 2, 4096, 2);
    load_source_frame();
    mixed_traffic(30);
    send_item(bir_pkg::REQ_FETCH, 4095, 1, '0);

    // Random geometries until the item budget is spent.
    while (loads_sent + fetches_sent < ITEM_TARGET) begin
      sw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 9);
      sh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
      if (sw > 40 && sh > 2) sh = 2;
      sel = $urandom_range(0, 9);
      dw = (sel < 7) ? $urandom_range(0, 40) : (sel < 9) ? $urandom_range(41, 600) :
           $urandom_range(4000, 8191);
      sel = $urandom_range(0, 9);
      dh = (sel < 7) ? $urandom_range(0, 40) : (sel < 9) ? $urandom_range(41, 600) :
           $urandom_range(4000, 8191);
      set_geometry(sw, sh, dw, dh, $urandom_range(0, 7));
      burst_mode = ($urandom_range(0, 3) == 0);
      load_source_frame();
      if (setups == 9) hold_kick <= ~hold_kick;
      mixed_traffic($urandom_range(30, 60));
      burst_mode = 1'b0;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d source loads and %0d fetches over %0d register setups,",
             loads_sent, fetches_sent, setups);
    $display("with %0d scaled pixels compared against the predictor.", pixels_checked);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
